// ----- hdl/fifo_tlb_core_assert.svh -----
// Assertion macros for the fifo_tlb_core checker.
// Standalone header; the includer supplies clock, reset and signals.
`ifndef FIFO_TLB_CORE_ASSERT_SVH
`define FIFO_TLB_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define FTLB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fifo_tlb_core: same-cycle check failed");

// Next-cycle implication, disabled while rst_n is low.
`define FTLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fifo_tlb_core: next-cycle check failed");

`endif

// ----- hdl/ftlb_pkg.sv -----
// Shared types and constants of the translation buffer.
// No dependencies; compiled before every other file.
package ftlb_pkg;

    localparam int OP_W        = 2;
    localparam int PAGE_W      = 52;
    localparam int FRAME_W     = 40;
    localparam int OCC_W       = 5;
    localparam int CFG_W       = 5;
    localparam int IDX_MAX_W   = 8;   // covers the largest buffer of 256 entries
    localparam int CNT_W       = 9;   // holds any entry count up to 256
    localparam int ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_W-1:0] ENTRIES_RESET      = 5'd16;
    localparam logic             REG_ENTRIES_IN_USE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP     = 2'd0,
        OP_INSERT     = 2'd1,
        OP_INVALIDATE = 2'd2
    } t_op;

    // Classified command handed from front to back
    typedef struct packed {
        t_op                  op;
        logic [PAGE_W-1:0]    page;
        logic [FRAME_W-1:0]   frame;
        logic                 hit;
        logic [IDX_MAX_W-1:0] idx;
    } t_cmd;

endpackage

// ----- hdl/ftlb_in_if.sv -----
// Request channel: valid/ready handshake carrying one buffer operation.
// Depends on ftlb_pkg.
interface ftlb_in_if;
    import ftlb_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_in;

    modport source (output valid, opcode, page_number, frame_in, input ready);
    modport sink   (input valid, opcode, page_number, frame_in, output ready);
endinterface

// ----- hdl/ftlb_out_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
// Depends on ftlb_pkg.
interface ftlb_out_if;
    import ftlb_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, hit, frame_out, occupancy, input ready);
    modport sink   (input valid, hit, frame_out, occupancy, output ready);
endinterface

// ----- hdl/ftlb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ftlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/ftlb_queue.sv -----
// Short command queue between the classifying front and executing back.
// Depends on ftlb_pkg.
module ftlb_queue #(
    parameter int DEPTH = ftlb_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ftlb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ftlb_pkg::t_cmd o_head,
    output logic          o_empty
);
    import ftlb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            w_full, w_push, w_pop;

    assign o_empty = (r_count == '0);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_push  = i_push && !w_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

// ----- hdl/ftlb_front.sv -----
// Front end: accepts a request, compares its page against every entry in use,
// picks the lowest matching slot and pushes a classified command. Uses ftlb_pkg.
module ftlb_front #(
    parameter int ENTRIES = ftlb_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ftlb_in_if.sink                    i_in,
    input  logic [ftlb_pkg::CFG_W-1:0] i_active,
    input  logic [ENTRIES-1:0]         i_valid,
    input  logic [ftlb_pkg::PAGE_W-1:0] i_tags [ENTRIES],
    input  logic                       i_commit,
    output logic                       o_push,
    output ftlb_pkg::t_cmd             o_cmd
);
    import ftlb_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_s1_valid, r_s2_valid;
    t_op                  r_s1_op, r_s2_op;
    logic [PAGE_W-1:0]    r_s1_page, r_s2_page;
    logic [FRAME_W-1:0]   r_s1_frame, r_s2_frame;
    logic [ENTRIES-1:0]   r_match, n_match;
    logic                 w_accept;
    logic                 w_hit;
    logic [IDX_MAX_W-1:0] w_idx;

    // one request in flight until the back end commits it
    assign i_in.ready = !r_busy || i_commit;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (i_commit) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i] = i_valid[i] && (CNT_W'(i) < CNT_W'(i_active))
                         && (i_tags[i] == r_s1_page);
        end
    end

    // lowest matching slot wins
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit = 1'b1;
                w_idx = IDX_MAX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op    <= t_op'(i_in.opcode);
            r_s1_page  <= i_in.page_number;
            r_s1_frame <= i_in.frame_in;
        end
        if (r_s1_valid) begin
            r_s2_op    <= r_s1_op;
            r_s2_page  <= r_s1_page;
            r_s2_frame <= r_s1_frame;
            r_match    <= n_match;
        end
    end

    assign o_push      = r_s2_valid;
    assign o_cmd.op    = r_s2_op;
    assign o_cmd.page  = r_s2_page;
    assign o_cmd.frame = r_s2_frame;
    assign o_cmd.hit   = w_hit;
    assign o_cmd.idx   = w_idx;
endmodule

// ----- hdl/ftlb_back.sv -----
// Back end: pops a command, updates tags, valid bits, pointer and fill count,
// drives the frame RAM and holds the result word. Uses ftlb_pkg, ftlb_ram.
module ftlb_back #(
    parameter int ENTRIES = ftlb_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ftlb_pkg::t_cmd              i_cmd,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic [ftlb_pkg::CFG_W-1:0]  i_active,
    output logic [ENTRIES-1:0]          o_valid,
    output logic [ftlb_pkg::PAGE_W-1:0] o_tags [ENTRIES],
    ftlb_out_if.source                  o_out
);
    import ftlb_pkg::*;

    localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [PAGE_W-1:0]  r_tags [ENTRIES];
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [OCC_W-1:0]   r_fill, n_fill;
    logic               r_out_valid;
    logic               r_out_hit, n_out_hit;
    logic               r_out_sel, n_out_sel;
    logic [OCC_W-1:0]   r_out_occ;
    logic [CNT_W-1:0]   w_ptr_ext, w_n_ext, w_slot_ext, w_next_ext;
    logic [PW-1:0]      w_slot;
    logic [PW-1:0]      w_idx;
    logic               w_enabled;
    logic               w_we, w_re;
    logic [FRAME_W-1:0] w_rdata;

    assign o_pop     = !i_empty && (!r_out_valid || o_out.ready);
    assign w_enabled = (i_active != '0);
    assign w_idx     = i_cmd.idx[PW-1:0];

    // an out-of-range pointer restarts at slot zero
    assign w_ptr_ext  = CNT_W'(r_ptr);
    assign w_n_ext    = CNT_W'(i_active);
    assign w_slot_ext = (w_ptr_ext >= w_n_ext) ? '0 : w_ptr_ext;
    assign w_next_ext = w_slot_ext + 1'b1;
    assign w_slot     = w_slot_ext[PW-1:0];

    always_comb begin
        n_valid   = r_valid;
        n_ptr     = r_ptr;
        n_fill    = r_fill;
        n_out_hit = 1'b0;
        n_out_sel = 1'b0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        if (o_pop && w_enabled) begin
            case (i_cmd.op)
                OP_LOOKUP: begin
                    n_out_hit = i_cmd.hit;
                    n_out_sel = i_cmd.hit;
                    w_re      = i_cmd.hit;
                end
                OP_INSERT: begin
                    w_we            = 1'b1;
                    n_valid[w_slot] = 1'b1;
                    n_ptr = (w_next_ext >= w_n_ext) ? '0 : w_next_ext[PW-1:0];
                    if (r_fill < i_active) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                OP_INVALIDATE: begin
                    n_out_hit = i_cmd.hit;
                    if (i_cmd.hit) begin
                        n_valid[w_idx] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_ptr   <= n_ptr;
            r_fill  <= n_fill;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tags[w_slot] <= i_cmd.page;
        end
        if (o_pop) begin
            r_out_hit <= n_out_hit;
            r_out_sel <= n_out_sel;
            r_out_occ <= n_fill;
        end
    end

    ftlb_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (i_cmd.frame),
        .i_re    (w_re),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign o_valid = r_valid;
    assign o_tags  = r_tags;

    assign o_out.valid     = r_out_valid;
    assign o_out.hit       = r_out_hit;
    assign o_out.frame_out = r_out_sel ? w_rdata : '0;
    assign o_out.occupancy = r_out_occ;
endmodule

// ----- hdl/fifo_tlb_core.sv -----
// Top level of the fully associative translation buffer with FIFO replacement.
// Depends on ftlb_pkg, ftlb_in_if, ftlb_out_if, ftlb_front, ftlb_queue, ftlb_back.
//
//  Channel   Dir  Handshake               Word
//  i_in      in   valid/ready             opcode, page_number, frame_in
//  o_out     out  valid/ready             hit, frame_out, occupancy
//  APB       in   psel/penable, pready=1  entries_in_use at byte address 0
//
// A request passes from acceptance to result in steps: its page is compared
// against all entries, the lowest match is picked and the command queued, and the
// back end carries it out and registers the result word.
// The next request is taken in the cycle the back end commits the previous one,
// so a new request is not taken before the previous one has been carried out.
// Reset (synchronous) clears valid bits, pointer and fill count at once.
// A stalled output holds its word; the queue holds the next command meanwhile.
module fifo_tlb_core #(
    parameter int ENTRIES = ftlb_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ftlb_in_if.sink                         i_in,
    ftlb_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ftlb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ftlb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ftlb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ftlb_pkg::*;

    logic [CFG_W-1:0]   r_entries;
    logic [CFG_W-1:0]   w_active;
    logic               w_reg_sel;
    logic [ENTRIES-1:0] w_valid;
    logic [PAGE_W-1:0]  w_tags [ENTRIES];
    logic               w_push, w_pop, w_empty;
    t_cmd               w_cmd_in, w_cmd_head;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == REG_ENTRIES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_entries <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? APB_DATA_W'(r_entries) : '0;

    // clamp to the physical entry count
    assign w_active = (CNT_W'(r_entries) > CNT_W'(ENTRIES)) ? CFG_W'(ENTRIES) : r_entries;

    ftlb_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_active (w_active),
        .i_valid  (w_valid),
        .i_tags   (w_tags),
        .i_commit (w_pop),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    ftlb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_head  (w_cmd_head),
        .o_empty (w_empty)
    );

    ftlb_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_active (w_active),
        .o_valid  (w_valid),
        .o_tags   (w_tags),
        .o_out    (o_out)
    );
endmodule

// ----- hdl/ftlb_checker.sv -----
// Port-level checker for fifo_tlb_core, bound to the top level below.
// Depends on ftlb_pkg and fifo_tlb_core_assert.svh.
`include "fifo_tlb_core_assert.svh"

module ftlb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_hit,
    input logic [ftlb_pkg::FRAME_W-1:0] i_out_frame,
    input logic [ftlb_pkg::OCC_W-1:0]   i_out_occ
);
    import ftlb_pkg::*;

    logic                     w_in_acc;
    logic                     w_out_stall;
    logic                     w_frame_nz;
    logic [FRAME_W+OCC_W:0]   w_out_word;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_frame_nz  = (i_out_frame != '0);
    assign w_out_word  = {i_out_hit, i_out_frame, i_out_occ};

    // a stalled result word holds
    `FTLB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(w_out_word))

    // a frame is only returned with a hit
    `FTLB_ASSERT_IMPL(a_frame_needs_hit, i_clk, i_rst_n, i_out_valid && w_frame_nz, i_out_hit)

    // one request in flight: no acceptance right after another
    `FTLB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !i_in_ready)

    // reset drops the result word
    `FTLB_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b1, !i_rst_n, !i_out_valid)
endmodule

bind fifo_tlb_core ftlb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit),
    .i_out_frame (o_out.frame_out),
    .i_out_occ   (o_out.occupancy)
);

// ----- tb/tb_fifo_tlb_core.sv -----
// Self-checking testbench for fifo_tlb_core: lookups, inserts and invalidates
// checked word by word against a shadow buffer copy or fixed expected words.
// Depends on ftlb_pkg, ftlb_in_if, ftlb_out_if and the fifo_tlb_core RTL.
module tb_fifo_tlb_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ftlb_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ENTRIES_ADDR =
        APB_ADDR_W'(4 * int'(REG_ENTRIES_IN_USE));
    localparam logic [PAGE_W-1:0]  PG_ONES = '1;
    localparam logic [FRAME_W-1:0] FR_ONES = '1;
    localparam int N_PHASES = 7;
    localparam int POOL_SIZE = 6;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [OCC_W-1:0]   occ;
    } t_xlat_word;

    typedef enum {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [CFG_W-1:0]   cfg;
        bit                 typed;
        t_xlat_word         want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ftlb_in_if  in_if();
    ftlb_out_if out_if();

    fifo_tlb_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the buffer
    logic [PAGE_W-1:0]  shadow_page[ENTRIES];
    logic [FRAME_W-1:0] shadow_frame[ENTRIES];
    bit                 shadow_valid[ENTRIES];
    int                 shadow_ptr;
    int                 shadow_fill;
    int                 shadow_entries;

    t_xlat_word xlat_expect_q[$];
    t_dir_row   dir_rows[$];
    logic [PAGE_W-1:0] page_pool[POOL_SIZE];

    int err_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int phase_cfg[N_PHASES] = '{16, 4, 1, 31, 0, 11, 16};
    int phase_snd[N_PHASES] = '{7, 7, 49, 49, 0, 0, 0};
    int phase_rcv[N_PHASES] = '{49, 49, 7, 7, 0, 0, 0};
    int phase_len[N_PHASES] = '{110, 110, 100, 110, 40, 110, 80};

    function automatic t_xlat_word tlb_predict(logic [OP_W-1:0] op,
                                               logic [PAGE_W-1:0] page,
                                               logic [FRAME_W-1:0] frame);
        t_xlat_word r;
        int n;
        int m;
        int slot;
        r = '0;
        n = (shadow_entries > ENTRIES) ? ENTRIES : shadow_entries;
        if (n != 0) begin
            // lowest-indexed valid match, n when none
            m = n;
            for (int i = n - 1; i >= 0; i--) begin
                if (shadow_valid[i] && shadow_page[i] == page) m = i;
            end
            case (op)
                OP_LOOKUP: begin
                    if (m < n) begin
                        r.hit = 1'b1;
                        r.frame = shadow_frame[m];
                    end
                end
                OP_INSERT: begin
                    slot = (shadow_ptr >= n) ? 0 : shadow_ptr;
                    shadow_page[slot] = page;
                    shadow_frame[slot] = frame;
                    shadow_valid[slot] = 1'b1;
                    shadow_ptr = (slot + 1 >= n) ? 0 : slot + 1;
                    if (shadow_fill < n) shadow_fill++;
                end
                OP_INVALIDATE: begin
                    if (m < n) begin
                        shadow_valid[m] = 1'b0;
                        r.hit = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.occ = OCC_W'(shadow_fill);
        return r;
    endfunction

    function automatic void row_op(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                                   logic [FRAME_W-1:0] frame);
        t_dir_row r;
        r = '{kind: ROW_ITEM, op: op, page: page, frame: frame, cfg: '0,
              typed: 1'b0, want: '0};
        dir_rows.push_back(r);
    endfunction

    function automatic void row_chk(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                                    logic [FRAME_W-1:0] frame, logic hit,
                                    logic [FRAME_W-1:0] fout, logic [OCC_W-1:0] occ);
        t_dir_row r;
        r = '{kind: ROW_ITEM, op: op, page: page, frame: frame, cfg: '0,
              typed: 1'b1, want: '{hit: hit, frame: fout, occ: occ}};
        dir_rows.push_back(r);
    endfunction

    function automatic void row_cfg(logic [CFG_W-1:0] v);
        t_dir_row r;
        r = '{kind: ROW_CFG, op: '0, page: '0, frame: '0, cfg: v,
              typed: 1'b0, want: '0};
        dir_rows.push_back(r);
    endfunction

    function automatic logic [PAGE_W-1:0] rand_page_bits();
        return PAGE_W'({$urandom(), $urandom()});
    endfunction

    function automatic void refresh_pool();
        page_pool[0] = rand_page_bits();
        for (int i = 1; i < POOL_SIZE; i++) begin
            case ($urandom_range(0, 5))
                0: page_pool[i] = '0;
                1: page_pool[i] = PG_ONES;
                // near miss: one bit away from another pool page
                2: page_pool[i] = page_pool[0] ^ (PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
                default: page_pool[i] = rand_page_bits();
            endcase
        end
    endfunction

    task automatic note_mismatch(string msg);
        err_count++;
        if (err_count <= 10) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic send_item(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                             logic [FRAME_W-1:0] frame, bit typed, t_xlat_word want);
        t_xlat_word predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.opcode <= op;
        in_if.page_number <= page;
        in_if.frame_in <= frame;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = tlb_predict(op, page, frame);
        xlat_expect_q.push_back(typed ? want : predicted);
    endtask

    // Write entries_in_use once the buffer has drained, then read it back
    task automatic set_entries(logic [CFG_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        in_if.valid <= 1'b0;
        while (xlat_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ENTRIES_ADDR;
        pwdata <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        shadow_entries = int'(v);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_W-1:0] !== v)
            note_mismatch($sformatf("entries_in_use read back %0d, wrote %0d",
                                    rd[CFG_W-1:0], v));
    endtask

    // Check each result word against the oldest expectation; drive ready
    always @(posedge i_clk) begin
        t_xlat_word got;
        t_xlat_word want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{hit: out_if.hit, frame: out_if.frame_out, occ: out_if.occupancy};
            if (xlat_expect_q.size() == 0) begin
                note_mismatch($sformatf("unexpected word hit %0b frame %h occ %0d",
                                        got.hit, got.frame, got.occ));
            end else begin
                want = xlat_expect_q.pop_front();
                if (got.hit !== want.hit || got.frame !== want.frame
                        || got.occ !== want.occ)
                    note_mismatch($sformatf(
                        "hit %0b/%0b frame %h/%h occ %0d/%0d (expected/actual)",
                        want.hit, got.hit, want.frame, got.frame, want.occ, got.occ));
            end
        end
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int r;
        logic [OP_W-1:0] op;
        logic [PAGE_W-1:0] page;
        in_if.valid = 1'b0;
        in_if.opcode = '0;
        in_if.page_number = '0;
        in_if.frame_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        shadow_entries = int'(ENTRIES_RESET);
        shadow_ptr = 0;
        shadow_fill = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_page[i] = '0;
            shadow_frame[i] = '0;
            shadow_valid[i] = 1'b0;
        end

        // Empty after reset, then fill, duplicates and lowest-index match
        row_chk(OP_LOOKUP, '0, '0, 1'b0, '0, 5'd0);
        row_chk(OP_INVALIDATE, PG_ONES, '0, 1'b0, '0, 5'd0);
        row_chk(OP_RESERVED, PG_ONES, FR_ONES, 1'b0, '0, 5'd0);
        row_chk(OP_INSERT, PG_ONES, FR_ONES, 1'b0, '0, 5'd1);
        row_chk(OP_LOOKUP, PG_ONES, '0, 1'b1, FR_ONES, 5'd1);
        row_chk(OP_INSERT, '0, '0, 1'b0, '0, 5'd2);
        row_chk(OP_LOOKUP, '0, FR_ONES, 1'b1, '0, 5'd2);
        row_op(OP_INSERT, '0, 40'h55_5555_5555);
        row_op(OP_LOOKUP, '0, '0);
        row_op(OP_INVALIDATE, '0, '0);
        row_op(OP_LOOKUP, '0, '0);
        row_op(OP_RESERVED, '0, 40'hAA_AAAA_AAAA);
        // Disabled buffer: nothing changes
        row_cfg(5'd0);
        row_chk(OP_INSERT, 52'hA_AAAA_AAAA_AAAA, FR_ONES, 1'b0, '0, 5'd3);
        row_chk(OP_LOOKUP, PG_ONES, '0, 1'b0, '0, 5'd3);
        row_chk(OP_INVALIDATE, '0, '0, 1'b0, '0, 5'd3);
        // Register above the buffer size clamps
        row_cfg(5'd31);
        row_chk(OP_LOOKUP, PG_ONES, '0, 1'b1, FR_ONES, 5'd3);
        // Shrink below the pointer and below the fill count
        row_cfg(5'd2);
        row_chk(OP_INSERT, 52'h123, 40'h456, 1'b0, '0, 5'd3);
        row_op(OP_LOOKUP, PG_ONES, '0);
        row_op(OP_LOOKUP, 52'h123, '0);
        row_op(OP_INSERT, 52'h777, 40'h1);
        row_op(OP_INSERT, 52'h888, 40'h2);
        // Slots outside the window keep their contents
        row_cfg(5'd16);
        row_op(OP_LOOKUP, '0, '0);
        row_op(OP_LOOKUP, 52'h123, '0);
        row_op(OP_INVALIDATE, 52'h777, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 7;
        recv_idle_pct = 49;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                set_entries(dir_rows[k].cfg);
            end else begin
                send_item(dir_rows[k].op, dir_rows[k].page, dir_rows[k].frame,
                          dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_entries(CFG_W'(phase_cfg[p]));
            send_idle_pct = phase_snd[p];
            recv_idle_pct = phase_rcv[p];
            refresh_pool();
            for (int j = 0; j < phase_len[p]; j++) begin
                r = $urandom_range(0, 99);
                if (r < 35) op = OP_INSERT;
                else if (r < 75) op = OP_LOOKUP;
                else if (r < 95) op = OP_INVALIDATE;
                else op = OP_RESERVED;
                // mostly pool pages so lookups and invalidates find matches
                if ($urandom_range(0, 99) < 85)
                    page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    page = rand_page_bits();
                send_item(op, page, FRAME_W'({$urandom(), $urandom()}), 1'b0, '0);
            end
        end

        in_if.valid <= 1'b0;
        while (xlat_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
